>>> sv/pee_pkg.sv
// ----------------------------------------------------------------------------
// pee_pkg: shared types and constants of the percent escape expander
// Holds the character codes, register indexes, budget limit, the controller
// state type and the command and status structs between the two halves.
// ----------------------------------------------------------------------------
package pee_pkg;

   // Longest command string; the output budget never exceeds twice this.
   localparam int MAX_LEN    = 4096;
   // Numbers with more digits than this are dropped.
   localparam int MAX_DIGITS = 5;

   // A 16-bit number has at most five decimal digits.
   localparam int NUM_DIGITS = 5;
   localparam int CNT_W      = 3;
   localparam int CW_W       = 14;

   localparam int BUDGET_CAP_RAW = 2 * MAX_LEN;
   localparam logic [CW_W-1:0] BUDGET_CAP =
      CW_W'((BUDGET_CAP_RAW > 16383) ? 16383 : BUDGET_CAP_RAW);

   // floor(v / 10) == (v * 52429) >> 19 for every 16-bit v.
   localparam logic [15:0] RECIP_TEN = 16'd52429;
   localparam int          RECIP_SHIFT = 19;

   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_A       = 8'h61;
   localparam logic [7:0] CH_V       = 8'h76;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NONE    = 8'h00;

   localparam logic [1:0] CSR_AUDIO  = 2'd0;
   localparam logic [1:0] CSR_VIDEO  = 2'd1;
   localparam logic [1:0] CSR_BUDGET = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_CONV,
      ST_PLAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load_item;
      logic plan_chars;
      logic load_num;
      logic conv_step;
      logic plan_num;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic is_number;
      logic conv_last;
      logic emit_none;
      logic emit_one;
      logic out_free;
   } dp_status_type;

endpackage

>>> sv/pee_ctrl.sv
// ----------------------------------------------------------------------------
// pee_ctrl: sequencer of the percent escape expander
// Walks each request through decode, digit conversion and budget planning
// (numbers only) and emission; sends a command word per cycle to the datapath.
// ----------------------------------------------------------------------------
module pee_ctrl
   import pee_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = status.is_number ? ST_CONV : ST_EMIT;
         end
         ST_CONV: begin
            if (status.conv_last) begin
               state_in = ST_PLAN;
            end
         end
         ST_PLAN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.emit_none) begin
               state_in = ST_IDLE;
            end else if (status.out_free && status.emit_one) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready    = 1'b1;
            cmd.load_item = req_tvalid;
         end
         ST_DECODE: begin
            cmd.load_num   = status.is_number;
            cmd.plan_chars = !status.is_number;
         end
         ST_CONV: begin
            cmd.conv_step = 1'b1;
         end
         ST_PLAN: begin
            cmd.plan_num = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = !status.emit_none && status.out_free;
         end
         default: begin
         end
      endcase
   end

endmodule

>>> sv/pee_datapath.sv
// ----------------------------------------------------------------------------
// pee_datapath: registers and arithmetic of the percent escape expander
// Holds configuration, escape and budget state, the digit converter, the
// emission slots and the result register.
// ----------------------------------------------------------------------------
module pee_datapath
   import pee_pkg::*;
#(
   parameter int MAX_LEN    = pee_pkg::MAX_LEN,
   parameter int MAX_DIGITS = pee_pkg::MAX_DIGITS
)
(
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   input  logic [7:0]    req_tdata,
   input  logic          req_tlast,
   input  logic          csr_we,
   input  logic [1:0]    csr_index,
   input  logic [15:0]   csr_wdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [7:0]    rsp_tdata,
   output logic [1:0]    rsp_tuser,
   output logic          rsp_tlast
);

   // The budget never exceeds twice the longest string, nor the register.
   localparam int              LEN_CAP_RAW = 2 * MAX_LEN;
   localparam logic [CW_W-1:0] LEN_CAP     =
      CW_W'((LEN_CAP_RAW > 16383) ? 16383 : LEN_CAP_RAW);

   logic [15:0]     audio_ff, audio_in;
   logic [15:0]     video_ff, video_in;
   logic [CW_W-1:0] budget_ff, budget_in;
   logic            pending_ff, pending_in;
   logic [CW_W-1:0] cw_ff, cw_in;
   logic [7:0]      char_ff, char_in;
   logic            fin_ff, fin_in;
   logic [15:0]     value_ff, value_in;
   logic [CNT_W-1:0] ndig_ff, ndig_in;
   logic [NUM_DIGITS-1:0][7:0] slot_ff, slot_in;
   logic [CNT_W-1:0] emit_cnt_ff, emit_cnt_in;
   logic            marker_ff, marker_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      rsp_char_ff, rsp_char_in;
   logic            rsp_cv_ff, rsp_cv_in;
   logic            rsp_last_ff, rsp_last_in;
   logic            rsp_end_ff, rsp_end_in;

   logic [CW_W-1:0] budget_eff;
   logic [CW_W:0]   cw_ext;
   logic [CW_W:0]   be_ext;
   logic            fit1;
   logic            fit2;
   logic            num_fits;
   logic [31:0]     prod;
   logic [12:0]     quot;
   logic [16:0]     quot_ten;
   logic [3:0]      rem;
   logic [1:0]      want;
   logic [7:0]      ch0;
   logic [7:0]      ch1;
   logic            set_pend;
   logic [CNT_W-1:0] chars_cnt;

   always_ff @(posedge clock) begin
      if (reset) begin
         audio_ff     <= '0;
         video_ff     <= '0;
         budget_ff    <= '0;
         pending_ff   <= 1'b0;
         cw_ff        <= '0;
         emit_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         audio_ff     <= audio_in;
         video_ff     <= video_in;
         budget_ff    <= budget_in;
         pending_ff   <= pending_in;
         cw_ff        <= cw_in;
         emit_cnt_ff  <= emit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff     <= char_in;
      fin_ff      <= fin_in;
      value_ff    <= value_in;
      ndig_ff     <= ndig_in;
      slot_ff     <= slot_in;
      marker_ff   <= marker_in;
      rsp_char_ff <= rsp_char_in;
      rsp_cv_ff   <= rsp_cv_in;
      rsp_last_ff <= rsp_last_in;
      rsp_end_ff  <= rsp_end_in;
   end

   // Budget checks and one step of division by ten.
   always_comb begin
      budget_eff = (budget_ff < LEN_CAP) ? budget_ff : LEN_CAP;
      cw_ext     = {1'b0, cw_ff};
      be_ext     = {1'b0, budget_eff};
      fit1       = cw_ff < budget_eff;
      fit2       = (cw_ext + 15'd1) < be_ext;
      num_fits   = ({1'b0, ndig_ff} <= 4'(MAX_DIGITS))
                   && ((cw_ext + 15'(ndig_ff)) <= be_ext);
      prod       = value_ff * RECIP_TEN;
      quot       = prod[31:RECIP_SHIFT];
      quot_ten   = 17'({quot, 3'b000}) + 17'({quot, 1'b0});
      rem        = 4'({1'b0, value_ff} - quot_ten);
   end

   // What a plain character request writes, before the budget is applied.
   always_comb begin
      want     = 2'd1;
      ch0      = char_ff;
      ch1      = char_ff;
      set_pend = 1'b0;
      if (pending_ff) begin
         ch0 = CH_PERCENT;
         if (char_ff != CH_PERCENT) begin
            want = 2'd2;
         end
      end else if (char_ff == CH_PERCENT && !fin_ff) begin
         want     = 2'd0;
         set_pend = 1'b1;
      end
      case (want)
         2'd0:    chars_cnt = '0;
         2'd1:    chars_cnt = CNT_W'(fit1);
         default: chars_cnt = CNT_W'(fit1) + CNT_W'(fit2);
      endcase
   end

   always_comb begin
      audio_in     = audio_ff;
      video_in     = video_ff;
      budget_in    = budget_ff;
      pending_in   = pending_ff;
      cw_in        = cw_ff;
      char_in      = char_ff;
      fin_in       = fin_ff;
      value_in     = value_ff;
      ndig_in      = ndig_ff;
      slot_in      = slot_ff;
      emit_cnt_in  = emit_cnt_ff;
      marker_in    = marker_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_cv_in    = rsp_cv_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_end_in   = rsp_end_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_AUDIO:  audio_in  = csr_wdata;
            CSR_VIDEO:  video_in  = csr_wdata;
            CSR_BUDGET: budget_in = csr_wdata[CW_W-1:0];
            default: begin
            end
         endcase
      end

      if (cmd.load_item) begin
         char_in = req_tdata;
         fin_in  = req_tlast;
      end

      if (cmd.load_num) begin
         value_in = (char_ff == CH_A) ? audio_ff : video_ff;
         ndig_in  = '0;
      end

      // Digits come out least significant first and are pushed in at the
      // bottom, so the most significant one ends up in slot zero.
      if (cmd.conv_step) begin
         value_in = {3'b000, quot};
         ndig_in  = ndig_ff + CNT_W'(1);
         for (int i = NUM_DIGITS - 1; i > 0; i--) begin
            slot_in[i] = slot_ff[i-1];
         end
         slot_in[0] = CH_ZERO | {4'b0000, rem};
      end

      if (cmd.plan_chars) begin
         pending_in = set_pend;
         slot_in[0] = ch0;
         slot_in[1] = ch1;
         marker_in  = 1'b0;
         emit_cnt_in = chars_cnt;
         cw_in      = cw_ff + CW_W'(chars_cnt);
         if (fin_ff) begin
            cw_in = '0;
            if (chars_cnt == '0) begin
               emit_cnt_in = CNT_W'(1);
               marker_in   = 1'b1;
               slot_in[0]  = CH_NONE;
            end
         end
      end

      if (cmd.plan_num) begin
         pending_in  = 1'b0;
         marker_in   = 1'b0;
         emit_cnt_in = num_fits ? ndig_ff : '0;
         cw_in       = num_fits ? (cw_ff + CW_W'(ndig_ff)) : cw_ff;
         if (fin_ff) begin
            cw_in = '0;
            if (!num_fits) begin
               emit_cnt_in = CNT_W'(1);
               marker_in   = 1'b1;
               slot_in[0]  = CH_NONE;
            end
         end
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = slot_ff[0];
         rsp_cv_in    = !marker_ff;
         rsp_last_in  = emit_cnt_ff == CNT_W'(1);
         rsp_end_in   = (emit_cnt_ff == CNT_W'(1)) && fin_ff;
         emit_cnt_in  = emit_cnt_ff - CNT_W'(1);
         for (int i = 0; i < NUM_DIGITS - 1; i++) begin
            slot_in[i] = slot_ff[i+1];
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign status.is_number = pending_ff && (char_ff == CH_A || char_ff == CH_V);
   assign status.conv_last = value_ff < 16'd10;
   assign status.emit_none = emit_cnt_ff == '0;
   assign status.emit_one  = emit_cnt_ff == CNT_W'(1);
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tuser  = {rsp_end_ff, rsp_cv_ff};
   assign rsp_tlast  = rsp_last_ff;

   // A new result may only overwrite a slot that is empty or being taken.
   emit_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten while still held");

   // The end of a string is always the last result of its request.
   end_is_run_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_end_ff) |-> rsp_last_ff)
      else $error("text end flagged on a result that is not run last");

   // A final request leaves no escape or budget state behind.
   final_clears_state: assert property (@(posedge clock) disable iff (reset)
      ((cmd.plan_chars || cmd.plan_num) && fin_ff) |=> (cw_ff == '0 && !pending_ff))
      else $error("state not cleared after final request");

   // Conversion never produces more digits than a 16-bit value has.
   digit_count_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.conv_step |-> (ndig_ff < CNT_W'(NUM_DIGITS)))
      else $error("digit converter ran past five digits");

endmodule

>>> sv/percent_escape_expander.sv
// ----------------------------------------------------------------------------
// percent_escape_expander: streaming expander of percent escapes
// Takes a command string one byte per request and returns the expanded text
// one byte per response, within a per-string output budget.
// ----------------------------------------------------------------------------
// Each request carries one byte of a command string in req_tdata, with
// req_tlast on the byte that ends it. A pair "%%" becomes "%", "%a" and "%v"
// become the decimal text of the audio and video numbers (no leading zeros),
// a '%' followed by any other byte becomes '%' and that byte, and a '%' that
// ends the string becomes '%'. The number of bytes written per string is held
// to the output budget (capped at twice the longest string length): a single
// byte that does not fit is dropped, and a number is written only when all of
// its digits fit. Every response carries one byte; rsp_tlast marks the last
// response caused by a request, and a request can cause none (an escape that
// is still open). The final request of a string always causes at least one
// response: if it writes no byte, a bare end marker with char_valid low and
// a zero byte is sent; the last response of the string has text_end high.
// The block works on one request at a time. A request that writes plain bytes
// passes through accept, decode and emit; a number escape passes through
// accept, decode, a divide-by-ten step that converts one digit per cycle,
// budget planning and emit. Emission stalls while the result register is
// held by the consumer. Configuration is to be written by the user through
// csr_we/csr_index/csr_wdata between requests; the block itself does not
// enforce this. Index 0 is the audio number, 1 the video number, 2 the
// output budget; other indexes are ignored. The configuration registers and
// the escape, budget and output state reset to zero. The parameter MAX_LEN
// sets the budget cap and MAX_DIGITS the longest number that is ever written.
// ----------------------------------------------------------------------------
module percent_escape_expander
   import pee_pkg::*;
#(
   parameter int MAX_LEN    = pee_pkg::MAX_LEN,
   parameter int MAX_DIGITS = pee_pkg::MAX_DIGITS
)
(
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tlast,   // is_final
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_char
   output logic [1:0]  rsp_tuser,   // [0] char_valid, [1] text_end
   output logic        rsp_tlast,   // run_last
   // Configuration write port.
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // The sequencer decides what happens each cycle; the datapath acts only on
   // its command word and configuration writes and reports five status bits.
   pee_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pee_datapath #(
      .MAX_LEN    (MAX_LEN),
      .MAX_DIGITS (MAX_DIGITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> tb/sv/percent_escape_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// percent_escape_checker: expansion predictor and response scoreboard
// Watches the request, response and configuration ports of the percent escape
// expander, predicts the expanded text of each request and checks every
// response against it in order.
// ----------------------------------------------------------------------------
module percent_escape_checker
   import pee_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          fail_count,
   output int          expected_left,
   output int          requests_seen,
   output int          responses_seen
);

   typedef struct packed {
      logic [7:0] out_char;
      logic       char_valid;
      logic       run_last;
      logic       text_end;
   } text_byte_type;

   text_byte_type expected_text[$];
   text_byte_type request_text[$];
   logic [15:0] audio_value   = '0;
   logic [15:0] video_value   = '0;
   logic [13:0] budget_value  = '0;
   logic        escape_open   = 1'b0;
   int          bytes_written = 0;
   int          mismatches    = 0;
   int          n_requests    = 0;
   int          n_responses   = 0;

   // The budget register can hold more than the block ever allows.
   function automatic int budget_limit();
      return (budget_value < BUDGET_CAP) ? int'(budget_value) : int'(BUDGET_CAP);
   endfunction

   function automatic text_byte_type plain_byte(input logic [7:0] ch, input logic valid);
      text_byte_type b;
      b.out_char   = ch;
      b.char_valid = valid;
      b.run_last   = 1'b0;
      b.text_end   = 1'b0;
      return b;
   endfunction

   function automatic void write_byte(input logic [7:0] ch);
      if (bytes_written < budget_limit()) begin
         request_text.push_back(plain_byte(ch, 1'b1));
         bytes_written++;
      end
   endfunction

   // A number goes out whole or not at all.
   function automatic void write_decimal(input logic [15:0] value);
      logic [7:0]  digits[$];
      int unsigned rest;
      rest = value;
      do begin
         digits.push_front(CH_ZERO + 8'(rest % 10));
         rest = rest / 10;
      end while (rest != 0);
      if (digits.size() > MAX_DIGITS || bytes_written + digits.size() > budget_limit())
         return;
      foreach (digits[i])
         request_text.push_back(plain_byte(digits[i], 1'b1));
      bytes_written += digits.size();
   endfunction

   function automatic void expand_request(input logic [7:0] ch, input logic fin);
      text_byte_type b;
      request_text.delete();
      if (escape_open) begin
         escape_open = 1'b0;
         if (ch == CH_PERCENT)
            write_byte(CH_PERCENT);
         else if (ch == CH_A)
            write_decimal(audio_value);
         else if (ch == CH_V)
            write_decimal(video_value);
         else begin
            write_byte(CH_PERCENT);
            write_byte(ch);
         end
      end else if (ch == CH_PERCENT) begin
         if (fin)
            write_byte(CH_PERCENT);
         else
            escape_open = 1'b1;
      end else begin
         write_byte(ch);
      end
      if (fin) begin
         if (request_text.size() == 0)
            request_text.push_back(plain_byte(CH_NONE, 1'b0));
         escape_open   = 1'b0;
         bytes_written = 0;
      end
      foreach (request_text[i]) begin
         b = request_text[i];
         if (i == request_text.size() - 1) begin
            b.run_last = 1'b1;
            b.text_end = fin;
         end
         expected_text.push_back(b);
      end
   endfunction

   function automatic void check_response();
      text_byte_type want;
      text_byte_type got;
      got.out_char   = rsp_tdata;
      got.char_valid = rsp_tuser[0];
      got.run_last   = rsp_tlast;
      got.text_end   = rsp_tuser[1];
      n_responses++;
      if (expected_text.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("tb: response %0d not expected: char %02h valid %0b last %0b end %0b",
                     n_responses, got.out_char, got.char_valid, got.run_last, got.text_end);
         return;
      end
      want = expected_text.pop_front();
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("tb: response %0d expected char %02h valid %0b last %0b end %0b, %s",
                     n_responses, want.out_char, want.char_valid, want.run_last,
                     want.text_end,
                     $sformatf("got char %02h valid %0b last %0b end %0b",
                               got.out_char, got.char_valid, got.run_last, got.text_end));
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         expected_text.delete();
         audio_value   = '0;
         video_value   = '0;
         budget_value  = '0;
         escape_open   = 1'b0;
         bytes_written = 0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_response();
         if (req_tvalid && req_tready) begin
            n_requests++;
            expand_request(req_tdata, req_tlast);
         end
         if (csr_we) begin
            case (csr_index)
               CSR_AUDIO:  audio_value  = csr_wdata;
               CSR_VIDEO:  video_value  = csr_wdata;
               CSR_BUDGET: budget_value = csr_wdata[13:0];
               default: ;
            endcase
         end
      end
      fail_count     <= mismatches;
      expected_left  <= expected_text.size();
      requests_seen  <= n_requests;
      responses_seen <= n_responses;
   end

endmodule

>>> tb/sv/percent_escape_expander_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// percent_escape_expander_tb: self-checking bench of the escape expander
// Sends command strings with escapes, plain bytes and budget overflow under
// several register settings and random idling on both channels; a separate
// checker predicts every response and reports mismatches.
// ----------------------------------------------------------------------------
module percent_escape_expander_tb
   import pee_pkg::*;
();

   // Stop the run here if it has not finished; far above the slowest correct
   // run, where each request waits out the longest gap and every response
   // the longest stall.
   localparam int LIMIT_CYCLES = 400000;
   // Cycles to let pass after the last expected response before touching the
   // registers or ending the run. A request can leave the block busy without
   // causing a response.
   localparam int QUIET_CYCLES = 20;
   localparam int RANDOM_ITEMS = 400;
   localparam int PHASE_ITEMS  = 50;
   // Index with no register behind it; writes to it must be ignored.
   localparam logic [1:0] CSR_SPARE = 2'd3;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_index  = '0;
   logic [15:0] csr_wdata  = '0;

   // When set, both sides run flat out with no idling.
   logic        steady     = 1'b0;

   int fail_count;
   int expected_left;
   int requests_seen;
   int responses_seen;
   int items_sent  = 0;
   int stall_left  = 0;
   int cycle_count = 0;
   int phase_count = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   percent_escape_expander i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   percent_escape_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .expected_left  (expected_left),
      .requests_seen  (requests_seen),
      .responses_seen (responses_seen)
   );

   // Mostly short pauses, now and then a long one.
   function automatic int idle_length();
      return ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3) : $urandom_range(8, 30);
   endfunction

   // Bytes are biased toward the escape characters so that most strings hold
   // complete escapes; the rest is random noise over the whole byte range.
   function automatic logic [7:0] string_byte();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 30)
         return CH_PERCENT;
      if (pick < 40)
         return CH_A;
      if (pick < 50)
         return CH_V;
      return 8'($urandom_range(0, 255));
   endfunction

   // Numbers around digit-count boundaries plus fully random ones.
   function automatic logic [15:0] number_choice();
      case ($urandom_range(0, 7))
         0:       return 16'd0;
         1:       return 16'd9;
         2:       return 16'd10;
         3:       return 16'd65535;
         4:       return 16'($urandom_range(0, 99));
         default: return 16'($urandom);
      endcase
   endfunction

   // The two spare bits above the budget field are random; the block must
   // drop them. Small budgets are the common case since they make strings
   // overflow; the extremes come up in fixed phases.
   function automatic logic [15:0] budget_choice(input int phase);
      logic [1:0] spare;
      spare = 2'($urandom);
      case (phase)
         0:       return {spare, 14'h3FFF};
         2:       return {spare, 14'd0};
         4:       return {spare, 14'd8192};
         6:       return {spare, 14'd8193};
         7:       return {spare, 14'd1};
         default: return {spare, 14'($urandom_range(0, 24))};
      endcase
   endfunction

   // Each rising edge the consumer either keeps accepting, or starts or
   // continues a stall of random length.
   always @(posedge clock) begin
      if (reset || steady) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < 30) begin
         rsp_tready <= 1'b0;
         stall_left <= idle_length() - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Offers one request and returns at the edge where it is taken. The valid
   // stays high on return, so back-to-back requests never drop it; it is
   // lowered only at the start of a gap or when the stream goes quiet.
   task automatic send_request(input logic [7:0] ch, input logic fin);
      int gap;
      gap = (steady || $urandom_range(0, 1) == 0) ? 0 : idle_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tlast  <= fin;
      do @(posedge clock); while (req_tready !== 1'b1);
      items_sent++;
   endtask

   task automatic send_string(input int length);
      for (int i = 0; i < length; i++)
         send_request(string_byte(), i == length - 1);
   endtask

   // Stops the request stream and waits until the block has drained. The
   // first edge lets the checker's outstanding count catch up with a request
   // taken in this same step.
   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_left != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // Writes all registers in back-to-back cycles, ending with a write to the
   // unused index; the write enable is lowered only once, at the end.
   task automatic load_settings(input logic [15:0] audio, input logic [15:0] video,
                                input logic [15:0] budget);
      csr_we    <= 1'b1;
      csr_index <= CSR_AUDIO;
      csr_wdata <= audio;
      @(posedge clock);
      csr_index <= CSR_VIDEO;
      csr_wdata <= video;
      @(posedge clock);
      csr_index <= CSR_BUDGET;
      csr_wdata <= budget;
      @(posedge clock);
      csr_index <= CSR_SPARE;
      csr_wdata <= 16'($urandom);
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      int length;
      int phase_end;
      int random_goal;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      wait_quiet();

      // Directed part. A budget register above the cap with both number
      // extremes: every escape form, the zero and all-ones bytes, and a
      // percent sign that ends the string by itself or after an open escape.
      load_settings(16'd0, 16'd65535, 16'hFFFF);
      send_request(CH_PERCENT, 1'b0);
      send_request(CH_PERCENT, 1'b0);
      send_request(CH_PERCENT, 1'b0);
      send_request(CH_A, 1'b0);
      send_request(CH_PERCENT, 1'b0);
      send_request(CH_V, 1'b0);
      send_request(CH_PERCENT, 1'b0);
      send_request(8'h71, 1'b0);
      send_request(8'h00, 1'b0);
      send_request(8'hFF, 1'b0);
      send_request(CH_PERCENT, 1'b1);
      send_request(CH_PERCENT, 1'b0);
      send_request(CH_PERCENT, 1'b1);
      send_request(8'h78, 1'b1);
      wait_quiet();

      // A budget of three: the five-digit number is dropped while the
      // one-digit one fits, the plain bytes fill the rest, and the last byte
      // is dropped so the string closes with a bare end marker.
      load_settings(16'd7, 16'd12345, 16'h4003);
      send_request(CH_PERCENT, 1'b0);
      send_request(CH_V, 1'b0);
      send_request(CH_PERCENT, 1'b0);
      send_request(CH_A, 1'b0);
      send_request(8'h62, 1'b0);
      send_request(8'h63, 1'b0);
      send_request(8'h64, 1'b1);
      wait_quiet();

      // No budget at all: a final plain byte and a final number escape both
      // leave only the end marker.
      load_settings(16'd0, 16'd0, 16'h8000);
      send_request(8'h7A, 1'b1);
      send_request(CH_PERCENT, 1'b0);
      send_request(CH_A, 1'b1);

      // Random part, in phases of fresh settings. Strings are mostly short,
      // with an occasional long one, and every fourth phase runs without
      // idling on either side.
      random_goal = items_sent + RANDOM_ITEMS;
      while (items_sent < random_goal) begin
         wait_quiet();
         load_settings(number_choice(), number_choice(), budget_choice(phase_count));
         steady    <= (phase_count % 4 == 3);
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) begin
            length = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                 : $urandom_range(1, 12);
            send_string(length);
         end
         phase_count++;
      end
      wait_quiet();

      $display("tb: %0d requests over %0d random setting phases, %0d responses checked",
               requests_seen, phase_count, responses_seen);
      $display("tb: covered escapes, numbers, budget overflow, end markers and stalls");
      if (fail_count == 0 && expected_left == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
